>>> sv/dpf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dpf_pkg
// Shared widths, stage counts and the pipeline side-band record of the
// dipolar pair field unit.
// ----------------------------------------------------------------------------
package dpf_pkg;

  localparam int WORD_BITS  = 32;
  localparam int FRAC_BITS  = 16;
  localparam int MANT_BITS  = 20;
  localparam int UNIT_BITS  = 30;

  localparam int DIFF_BITS  = WORD_BITS + 1;
  localparam int EXP_BITS   = 6;
  localparam int ROOT_BITS  = MANT_BITS + 1;
  localparam int SQ_BITS    = 2 * MANT_BITS + 1;
  localparam int QU_BITS    = UNIT_BITS + 1;
  localparam int UX_BITS    = QU_BITS + 1;
  localparam int CUBE_BITS  = 3 * ROOT_BITS;
  localparam int AB_BITS    = WORD_BITS + UX_BITS;
  localparam int MAG_BITS   = AB_BITS - 1;
  localparam int HALF_BITS  = 32;
  localparam int PROD_BITS  = 2 * AB_BITS;
  localparam int TMAG_BITS  = PROD_BITS - 1;
  localparam int DOT_BITS   = 2 * WORD_BITS + 1;
  localparam int QF_BITS    = WORD_BITS;
  localparam int SH_BITS    = 7;
  localparam int FDIV_BITS  = 192;

  localparam int PRE_SHIFT  = 2 * FRAC_BITS - 2 * UNIT_BITS + 3 * (MANT_BITS - 1);
  localparam int SH_BASE    = 3 * (MANT_BITS - 1);

  localparam int NORM_LAT   = 4;
  localparam int SQRT_LAT   = ROOT_BITS + 1;
  localparam int UDIV_LAT   = QU_BITS;
  localparam int PROJ_LAT   = 9;
  localparam int FDIV_LAT   = QF_BITS + 2;

  localparam int I_NORM     = NORM_LAT;
  localparam int I_SQRT     = I_NORM + SQRT_LAT + 1;
  localparam int I_U        = I_SQRT + UDIV_LAT;
  localparam int I_P        = I_U + PROJ_LAT;
  localparam int I_F        = I_P + FDIV_LAT;

  typedef struct packed {
    logic                        valid;
    logic                        present;
    logic                        zero;
    logic                        neg_x;
    logic                        neg_y;
    logic signed [EXP_BITS-1:0]  e;
    logic [MANT_BITS-1:0]        nx;
    logic [MANT_BITS-1:0]        ny;
    logic [ROOT_BITS-1:0]        d;
    logic [CUBE_BITS-1:0]        v;
    logic signed [WORD_BITS-1:0] mix;
    logic signed [WORD_BITS-1:0] miy;
    logic signed [WORD_BITS-1:0] mjx;
    logic signed [WORD_BITS-1:0] mjy;
    logic                        neg_par;
    logic                        neg_perp;
  } side_t;

endpackage
`default_nettype wire

>>> sv/dpf_norm.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dpf_norm
// Separation vector, magnitudes, exponent search and mantissa alignment.
// ----------------------------------------------------------------------------
module dpf_norm import dpf_pkg::*; (
  input  logic                        clk,
  input  logic                        en,
  input  logic signed [WORD_BITS-1:0] pos_self_x,
  input  logic signed [WORD_BITS-1:0] pos_self_y,
  input  logic signed [WORD_BITS-1:0] pos_other_x,
  input  logic signed [WORD_BITS-1:0] pos_other_y,
  output logic [MANT_BITS-1:0]        nx,
  output logic [MANT_BITS-1:0]        ny,
  output logic signed [EXP_BITS-1:0]  e,
  output logic                        neg_x,
  output logic                        neg_y,
  output logic                        zero
);

  logic signed [DIFF_BITS-1:0] rx, ry;
  logic [DIFF_BITS-1:0]        ax_s2, ay_s2, mx_s2;
  logic                        negx_s2, negy_s2;
  logic [DIFF_BITS-1:0]        ax_s3, ay_s3;
  logic                        negx_s3, negy_s3, zero_s3;
  logic signed [EXP_BITS-1:0]  e_s3, e_next;
  logic [EXP_BITS-1:0]         blen, sh_amt;
  logic [MANT_BITS-1:0]        nx_next, ny_next;

  always_comb begin
    blen = '0;
    for (int i = 0; i < DIFF_BITS; i++) begin
      if (mx_s2[i]) blen = EXP_BITS'(i + 1);
    end
    e_next = EXP_BITS'(int'(blen) - MANT_BITS);
  end

  always_comb begin
    sh_amt = (e_s3 > 0) ? e_s3 : -e_s3;
    if (e_s3 > 0) begin
      nx_next = MANT_BITS'(ax_s3 >> sh_amt);
      ny_next = MANT_BITS'(ay_s3 >> sh_amt);
    end else begin
      nx_next = MANT_BITS'(ax_s3 << sh_amt);
      ny_next = MANT_BITS'(ay_s3 << sh_amt);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rx      <= DIFF_BITS'(pos_other_x) - DIFF_BITS'(pos_self_x);
      ry      <= DIFF_BITS'(pos_other_y) - DIFF_BITS'(pos_self_y);
      ax_s2   <= (rx < 0) ? DIFF_BITS'(-rx) : DIFF_BITS'(rx);
      ay_s2   <= (ry < 0) ? DIFF_BITS'(-ry) : DIFF_BITS'(ry);
      mx_s2   <= ((rx < 0 ? -rx : rx) > (ry < 0 ? -ry : ry)) ?
                 DIFF_BITS'(rx < 0 ? -rx : rx) : DIFF_BITS'(ry < 0 ? -ry : ry);
      negx_s2 <= rx < 0;
      negy_s2 <= ry < 0;
      ax_s3   <= ax_s2;
      ay_s3   <= ay_s2;
      negx_s3 <= negx_s2;
      negy_s3 <= negy_s2;
      zero_s3 <= mx_s2 == '0;
      e_s3    <= e_next;
      nx      <= nx_next;
      ny      <= ny_next;
      e       <= e_s3;
      neg_x   <= negx_s3;
      neg_y   <= negy_s3;
      zero    <= zero_s3;
    end
  end

endmodule
`default_nettype wire

>>> sv/dpf_isqrt.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dpf_isqrt
// Squared length of the mantissa vector, then an integer square root that
// settles one root bit per stage.
// ----------------------------------------------------------------------------
module dpf_isqrt import dpf_pkg::*; (
  input  logic                 clk,
  input  logic                 en,
  input  logic [MANT_BITS-1:0] nx,
  input  logic [MANT_BITS-1:0] ny,
  output logic [ROOT_BITS-1:0] root
);

  localparam int RW = SQ_BITS + 3;

  logic [RW-1:0]        rem_q  [0:ROOT_BITS];
  logic [ROOT_BITS-1:0] root_q [0:ROOT_BITS];
  logic [RW-1:0]        trial  [0:ROOT_BITS-1];

  always_comb begin
    for (int g = 0; g < ROOT_BITS; g++) begin
      trial[g] = (RW'(root_q[g]) << (ROOT_BITS - g)) + (RW'(1) << (2 * (ROOT_BITS - 1 - g)));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_q[0]  <= RW'(nx) * RW'(nx) + RW'(ny) * RW'(ny);
      root_q[0] <= '0;
      for (int g = 0; g < ROOT_BITS; g++) begin
        if (rem_q[g] >= trial[g]) begin
          rem_q[g+1]  <= rem_q[g] - trial[g];
          root_q[g+1] <= root_q[g] | (ROOT_BITS'(1) << (ROOT_BITS - 1 - g));
        end else begin
          rem_q[g+1]  <= rem_q[g];
          root_q[g+1] <= root_q[g];
        end
      end
    end
  end

  assign root = root_q[ROOT_BITS];

endmodule
`default_nettype wire

>>> sv/dpf_udiv.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dpf_udiv
// Unit-vector divider: mantissa scaled by the unit width over the root,
// restoring, one quotient bit per stage.
// ----------------------------------------------------------------------------
module dpf_udiv import dpf_pkg::*; (
  input  logic                 clk,
  input  logic                 en,
  input  logic [MANT_BITS-1:0] num,
  input  logic [ROOT_BITS-1:0] den,
  output logic [QU_BITS-1:0]   quo
);

  localparam int RW = MANT_BITS + UNIT_BITS + 2;

  logic [RW-1:0]        rem_q [1:QU_BITS];
  logic [QU_BITS-1:0]   q_q   [1:QU_BITS];
  logic [ROOT_BITS-1:0] d_q   [1:QU_BITS];
  logic [RW-1:0]        rin   [0:QU_BITS-1];
  logic [QU_BITS-1:0]   qin   [0:QU_BITS-1];
  logic [ROOT_BITS-1:0] din   [0:QU_BITS-1];
  logic [RW-1:0]        dvs   [0:QU_BITS-1];

  always_comb begin
    rin[0] = RW'(num) << UNIT_BITS;
    qin[0] = '0;
    din[0] = den;
    for (int g = 1; g < QU_BITS; g++) begin
      rin[g] = rem_q[g];
      qin[g] = q_q[g];
      din[g] = d_q[g];
    end
    for (int g = 0; g < QU_BITS; g++) begin
      dvs[g] = RW'(din[g]) << (QU_BITS - 1 - g);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int g = 0; g < QU_BITS; g++) begin
        d_q[g+1] <= din[g];
        if (rin[g] >= dvs[g]) begin
          rem_q[g+1] <= rin[g] - dvs[g];
          q_q[g+1]   <= qin[g] | (QU_BITS'(1) << (QU_BITS - 1 - g));
        end else begin
          rem_q[g+1] <= rin[g];
          q_q[g+1]   <= qin[g];
        end
      end
    end
  end

  assign quo = q_q[QU_BITS];

endmodule
`default_nettype wire

>>> sv/dpf_proj.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dpf_proj
// Projections onto the unit vector, wide products split into partial
// products, and the numerators 3ab - (mj.mi) and 3ac - (mj.mi_perp).
// ----------------------------------------------------------------------------
module dpf_proj import dpf_pkg::*; (
  input  logic                        clk,
  input  logic                        en,
  input  logic [QU_BITS-1:0]          u_x,
  input  logic [QU_BITS-1:0]          u_y,
  input  logic                        neg_x,
  input  logic                        neg_y,
  input  logic signed [WORD_BITS-1:0] mix,
  input  logic signed [WORD_BITS-1:0] miy,
  input  logic signed [WORD_BITS-1:0] mjx,
  input  logic signed [WORD_BITS-1:0] mjy,
  output logic [TMAG_BITS-1:0]        mag_par,
  output logic [TMAG_BITS-1:0]        mag_perp,
  output logic                        neg_par,
  output logic                        neg_perp
);

  logic signed [UX_BITS-1:0]   ux0, uy0;
  logic signed [WORD_BITS-1:0] mix0, miy0, mjx0, mjy0;
  logic signed [AB_BITS-1:0]   pa1, pa2, pb1, pb2, pc1, pc2;
  logic signed [AB_BITS-1:0]   dp1, dp2, dq1, dq2;
  logic signed [AB_BITS-1:0]   a2, b2, c2;
  logic signed [DOT_BITS-1:0]  dpar2, dperp2, dpar3, dperp3, dpar4, dperp4;
  logic signed [DOT_BITS-1:0]  dpar5, dperp5, dpar6, dperp6;
  logic [MAG_BITS-1:0]         am3, bm3, cm3;
  logic                        sab3, sac3, sab4, sac4, sab5, sac5;
  logic [2*HALF_BITS-1:0]      ll_b, lh_b, hl_b, hh_b, ll_c, lh_c, hl_c, hh_c;
  logic [PROD_BITS-1:0]        sum_b, sum_c;
  logic signed [PROD_BITS-1:0] p_b, p_c, t_par, t_perp;

  always_ff @(posedge clk) begin
    if (en) begin
      ux0    <= neg_x ? -$signed({1'b0, u_x}) : $signed({1'b0, u_x});
      uy0    <= neg_y ? -$signed({1'b0, u_y}) : $signed({1'b0, u_y});
      mix0   <= mix;
      miy0   <= miy;
      mjx0   <= mjx;
      mjy0   <= mjy;

      pa1    <= AB_BITS'(mjx0) * AB_BITS'(ux0);
      pa2    <= AB_BITS'(mjy0) * AB_BITS'(uy0);
      pb1    <= AB_BITS'(mix0) * AB_BITS'(ux0);
      pb2    <= AB_BITS'(miy0) * AB_BITS'(uy0);
      pc1    <= AB_BITS'(mix0) * AB_BITS'(uy0);
      pc2    <= AB_BITS'(miy0) * AB_BITS'(ux0);
      dp1    <= AB_BITS'(mjx0) * AB_BITS'(mix0);
      dp2    <= AB_BITS'(mjy0) * AB_BITS'(miy0);
      dq1    <= AB_BITS'(mjy0) * AB_BITS'(mix0);
      dq2    <= AB_BITS'(mjx0) * AB_BITS'(miy0);

      a2     <= pa1 + pa2;
      b2     <= pb1 + pb2;
      c2     <= pc1 - pc2;
      dpar2  <= DOT_BITS'(dp1) + DOT_BITS'(dp2);
      dperp2 <= DOT_BITS'(dq1) - DOT_BITS'(dq2);

      am3    <= MAG_BITS'(a2 < 0 ? -a2 : a2);
      bm3    <= MAG_BITS'(b2 < 0 ? -b2 : b2);
      cm3    <= MAG_BITS'(c2 < 0 ? -c2 : c2);
      sab3   <= (a2 < 0) ^ (b2 < 0);
      sac3   <= (a2 < 0) ^ (c2 < 0);
      dpar3  <= dpar2;
      dperp3 <= dperp2;

      ll_b   <= (2*HALF_BITS)'(am3[HALF_BITS-1:0]) * (2*HALF_BITS)'(bm3[HALF_BITS-1:0]);
      lh_b   <= (2*HALF_BITS)'(am3[HALF_BITS-1:0]) * (2*HALF_BITS)'(bm3[MAG_BITS-1:HALF_BITS]);
      hl_b   <= (2*HALF_BITS)'(am3[MAG_BITS-1:HALF_BITS]) * (2*HALF_BITS)'(bm3[HALF_BITS-1:0]);
      hh_b   <= (2*HALF_BITS)'(am3[MAG_BITS-1:HALF_BITS]) *
                (2*HALF_BITS)'(bm3[MAG_BITS-1:HALF_BITS]);
      ll_c   <= (2*HALF_BITS)'(cm3[HALF_BITS-1:0]) * (2*HALF_BITS)'(am3[HALF_BITS-1:0]);
      lh_c   <= (2*HALF_BITS)'(am3[HALF_BITS-1:0]) * (2*HALF_BITS)'(cm3[MAG_BITS-1:HALF_BITS]);
      hl_c   <= (2*HALF_BITS)'(am3[MAG_BITS-1:HALF_BITS]) * (2*HALF_BITS)'(cm3[HALF_BITS-1:0]);
      hh_c   <= (2*HALF_BITS)'(am3[MAG_BITS-1:HALF_BITS]) *
                (2*HALF_BITS)'(cm3[MAG_BITS-1:HALF_BITS]);
      sab4   <= sab3;
      sac4   <= sac3;
      dpar4  <= dpar3;
      dperp4 <= dperp3;

      sum_b  <= PROD_BITS'(ll_b) + (PROD_BITS'(lh_b) << HALF_BITS) +
                (PROD_BITS'(hl_b) << HALF_BITS) + (PROD_BITS'(hh_b) << (2*HALF_BITS));
      sum_c  <= PROD_BITS'(ll_c) + (PROD_BITS'(lh_c) << HALF_BITS) +
                (PROD_BITS'(hl_c) << HALF_BITS) + (PROD_BITS'(hh_c) << (2*HALF_BITS));
      sab5   <= sab4;
      sac5   <= sac4;
      dpar5  <= dpar4;
      dperp5 <= dperp4;

      p_b    <= sab5 ? -$signed(sum_b) : $signed(sum_b);
      p_c    <= sac5 ? -$signed(sum_c) : $signed(sum_c);
      dpar6  <= dpar5;
      dperp6 <= dperp5;

      t_par  <= p_b + (p_b <<< 1) - (PROD_BITS'(dpar6) <<< (2*UNIT_BITS));
      t_perp <= p_c + (p_c <<< 1) - (PROD_BITS'(dperp6) <<< (2*UNIT_BITS));

      mag_par  <= TMAG_BITS'(t_par < 0 ? -t_par : t_par);
      mag_perp <= TMAG_BITS'(t_perp < 0 ? -t_perp : t_perp);
      neg_par  <= t_par < 0;
      neg_perp <= t_perp < 0;
    end
  end

endmodule
`default_nettype wire

>>> sv/dpf_fdiv.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dpf_fdiv
// Final scaling divide of a numerator magnitude by the cubed root, with an
// overflow test ahead of the quotient and one quotient bit per stage.
// ----------------------------------------------------------------------------
module dpf_fdiv import dpf_pkg::*; (
  input  logic                       clk,
  input  logic                       en,
  input  logic [TMAG_BITS-1:0]       mag,
  input  logic [CUBE_BITS-1:0]       cube,
  input  logic signed [EXP_BITS-1:0] e,
  output logic [QF_BITS-1:0]         quo,
  output logic                       ovf
);

  logic [SH_BITS-1:0]   sh;
  logic [FDIV_BITS-1:0] num0, den0, num1, den1;
  logic                 ovf1;
  logic [FDIV_BITS-1:0] rem_q [1:QF_BITS];
  logic [FDIV_BITS-1:0] den_q [1:QF_BITS];
  logic [QF_BITS-1:0]   q_q   [1:QF_BITS];
  logic                 ov_q  [1:QF_BITS];
  logic [FDIV_BITS-1:0] rin   [0:QF_BITS-1];
  logic [FDIV_BITS-1:0] din   [0:QF_BITS-1];
  logic [QF_BITS-1:0]   qin   [0:QF_BITS-1];
  logic                 oin   [0:QF_BITS-1];
  logic [FDIV_BITS-1:0] dvs   [0:QF_BITS-1];

  assign sh = SH_BITS'(SH_BASE + 3 * int'(e));

  always_comb begin
    rin[0] = num1;
    din[0] = den1;
    qin[0] = '0;
    oin[0] = ovf1;
    for (int g = 1; g < QF_BITS; g++) begin
      rin[g] = rem_q[g];
      din[g] = den_q[g];
      qin[g] = q_q[g];
      oin[g] = ov_q[g];
    end
    for (int g = 0; g < QF_BITS; g++) begin
      dvs[g] = din[g] << (QF_BITS - 1 - g);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num0 <= FDIV_BITS'(mag) << PRE_SHIFT;
      den0 <= FDIV_BITS'(cube) << sh;
      num1 <= num0;
      den1 <= den0;
      ovf1 <= num0 >= (den0 << QF_BITS);
      for (int g = 0; g < QF_BITS; g++) begin
        den_q[g+1] <= din[g];
        ov_q[g+1]  <= oin[g];
        if (rin[g] >= dvs[g]) begin
          rem_q[g+1] <= rin[g] - dvs[g];
          q_q[g+1]   <= qin[g] | (QF_BITS'(1) << (QF_BITS - 1 - g));
        end else begin
          rem_q[g+1] <= rin[g];
          q_q[g+1]   <= qin[g];
        end
      end
    end
  end

  assign quo = q_q[QF_BITS];
  assign ovf = ov_q[QF_BITS];

endmodule
`default_nettype wire

>>> sv/dipolar_pair_field.sv
`timescale 1ns / 1ps
`default_nettype none
// Results leave through a registered output stage.
// Throughput: one request per cycle while the output is not stalled; every stage is a register stage.
// The output stall freezes the whole pipeline while it is held against a valid result.
// Reset clears the valid bits of every stage and the output valid.
// ----------------------------------------------------------------------------
// dipolar_pair_field
// Dipolar field of one neighbor spin projected onto a spin's own moment and
// its perpendicular, saturating signed fixed point.
// ----------------------------------------------------------------------------
module dipolar_pair_field import dpf_pkg::*; (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        pair_valid,
  output logic                        pair_stall,
  input  logic signed [WORD_BITS-1:0] pos_self_x,
  input  logic signed [WORD_BITS-1:0] pos_self_y,
  input  logic signed [WORD_BITS-1:0] pos_other_x,
  input  logic signed [WORD_BITS-1:0] pos_other_y,
  input  logic signed [WORD_BITS-1:0] moment_self_x,
  input  logic signed [WORD_BITS-1:0] moment_self_y,
  input  logic signed [WORD_BITS-1:0] moment_other_x,
  input  logic signed [WORD_BITS-1:0] moment_other_y,
  input  logic                        neighbor_present,
  output logic                        field_valid,
  input  logic                        field_stall,
  output logic signed [WORD_BITS-1:0] h_parallel,
  output logic signed [WORD_BITS-1:0] h_perpendicular,
  output logic                        saturated
);

  localparam logic [QF_BITS-1:0] LIM_POS = {1'b0, {(QF_BITS-1){1'b1}}};
  localparam logic [QF_BITS-1:0] LIM_NEG = {1'b1, {(QF_BITS-1){1'b0}}};

  typedef struct packed {
    logic                 sat;
    logic [QF_BITS-1:0]   val;
  } clip_t;

  function automatic clip_t clip(input logic [QF_BITS-1:0] q, input logic ov,
                                 input logic neg);
    logic [QF_BITS-1:0] lim;
    clip_t              r;
    lim   = neg ? LIM_NEG : LIM_POS;
    r.sat = ov || (q > lim);
    r.val = r.sat ? lim : q;
    r.val = neg ? -r.val : r.val;
    return r;
  endfunction

  logic                       en;
  side_t                      side [0:I_F];
  side_t                      side_in;
  logic [MANT_BITS-1:0]       norm_nx, norm_ny;
  logic signed [EXP_BITS-1:0] norm_e;
  logic                       norm_negx, norm_negy, norm_zero;
  logic [ROOT_BITS-1:0]       root;
  logic [QU_BITS-1:0]         u_x, u_y;
  logic [TMAG_BITS-1:0]       mag_par, mag_perp;
  logic                       neg_par, neg_perp;
  logic [QF_BITS-1:0]         q_par, q_perp;
  logic                       ovf_par, ovf_perp;
  clip_t                      c_par, c_perp;

  assign en         = !(field_valid && field_stall);
  assign pair_stall = !en;

  always_comb begin
    side_in         = '0;
    side_in.valid   = pair_valid;
    side_in.present = neighbor_present;
    side_in.mix     = moment_self_x;
    side_in.miy     = moment_self_y;
    side_in.mjx     = moment_other_x;
    side_in.mjy     = moment_other_y;
  end

  dpf_norm u_norm (
    .clk         (clk),
    .en          (en),
    .pos_self_x  (pos_self_x),
    .pos_self_y  (pos_self_y),
    .pos_other_x (pos_other_x),
    .pos_other_y (pos_other_y),
    .nx          (norm_nx),
    .ny          (norm_ny),
    .e           (norm_e),
    .neg_x       (norm_negx),
    .neg_y       (norm_negy),
    .zero        (norm_zero)
  );

  dpf_isqrt u_isqrt (
    .clk  (clk),
    .en   (en),
    .nx   (side[I_NORM].nx),
    .ny   (side[I_NORM].ny),
    .root (root)
  );

  dpf_udiv u_udiv_x (
    .clk (clk),
    .en  (en),
    .num (side[I_SQRT].nx),
    .den (side[I_SQRT].d),
    .quo (u_x)
  );

  dpf_udiv u_udiv_y (
    .clk (clk),
    .en  (en),
    .num (side[I_SQRT].ny),
    .den (side[I_SQRT].d),
    .quo (u_y)
  );

  dpf_proj u_proj (
    .clk      (clk),
    .en       (en),
    .u_x      (u_x),
    .u_y      (u_y),
    .neg_x    (side[I_U].neg_x),
    .neg_y    (side[I_U].neg_y),
    .mix      (side[I_U].mix),
    .miy      (side[I_U].miy),
    .mjx      (side[I_U].mjx),
    .mjy      (side[I_U].mjy),
    .mag_par  (mag_par),
    .mag_perp (mag_perp),
    .neg_par  (neg_par),
    .neg_perp (neg_perp)
  );

  dpf_fdiv u_fdiv_par (
    .clk  (clk),
    .en   (en),
    .mag  (mag_par),
    .cube (side[I_P].v),
    .e    (side[I_P].e),
    .quo  (q_par),
    .ovf  (ovf_par)
  );

  dpf_fdiv u_fdiv_perp (
    .clk  (clk),
    .en   (en),
    .mag  (mag_perp),
    .cube (side[I_P].v),
    .e    (side[I_P].e),
    .quo  (q_perp),
    .ovf  (ovf_perp)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      side[0] <= side_in;
      for (int k = 0; k < I_F; k++) begin
        side[k+1] <= side[k];
      end
      side[I_NORM].nx       <= norm_nx;
      side[I_NORM].ny       <= norm_ny;
      side[I_NORM].e        <= norm_e;
      side[I_NORM].neg_x    <= norm_negx;
      side[I_NORM].neg_y    <= norm_negy;
      side[I_NORM].zero     <= norm_zero;
      side[I_SQRT].d        <= root;
      side[I_SQRT].v        <= CUBE_BITS'(CUBE_BITS'(root) * CUBE_BITS'(root));
      side[I_SQRT+1].v      <= CUBE_BITS'(side[I_SQRT].v[2*ROOT_BITS-1:0]) *
                               CUBE_BITS'(side[I_SQRT].d);
      side[I_P+1].neg_par   <= neg_par;
      side[I_P+1].neg_perp  <= neg_perp;
    end
    if (rst) begin
      for (int k = 0; k <= I_F; k++) begin
        side[k].valid <= 1'b0;
      end
    end
  end

  always_comb begin
    c_par  = clip(q_par, ovf_par, side[I_F].neg_par);
    c_perp = clip(q_perp, ovf_perp, side[I_F].neg_perp);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      field_valid <= side[I_F].valid;
      if (!side[I_F].present) begin
        h_parallel      <= '0;
        h_perpendicular <= '0;
        saturated       <= 1'b0;
      end else if (side[I_F].zero) begin
        h_parallel      <= '0;
        h_perpendicular <= '0;
        saturated       <= 1'b1;
      end else begin
        h_parallel      <= $signed(c_par.val);
        h_perpendicular <= $signed(c_perp.val);
        saturated       <= c_par.sat || c_perp.sat;
      end
    end
    if (rst) begin
      field_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

>>> sv/dpf_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dpf_checker
// Port-level checks of the dipolar pair field unit, bound to the top level.
// ----------------------------------------------------------------------------
module dpf_checker import dpf_pkg::*; (
  input logic                        clk,
  input logic                        rst,
  input logic                        pair_valid,
  input logic                        pair_stall,
  input logic                        field_valid,
  input logic                        field_stall,
  input logic signed [WORD_BITS-1:0] h_parallel,
  input logic signed [WORD_BITS-1:0] h_perpendicular,
  input logic                        saturated
);

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    field_valid && field_stall |=> field_valid && $stable(h_parallel) &&
      $stable(h_perpendicular) && $stable(saturated))
    else $error("stalled result changed");

  a_stall_follows_output: assert property (@(posedge clk)
    pair_stall == (field_valid && field_stall))
    else $error("request stall does not follow the output stall");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !field_valid)
    else $error("result valid after reset");

  a_no_request_lost: assert property (@(posedge clk) disable iff (rst)
    pair_valid && pair_stall |-> field_valid)
    else $error("request stalled with no result waiting");

endmodule

bind dipolar_pair_field dpf_checker u_dpf_checker (.*);
`default_nettype wire

>>> sim/dipolar_pair_field_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dipolar_pair_field_test
// Streams spin pairs through the dipolar pair field unit and checks every
// result against an in-bench fixed-point prediction: directed extremes,
// absent and coincident neighbors, random pairs, long output back-pressure
// and a full drain pause.
// ----------------------------------------------------------------------------
module dipolar_pair_field_test;
  import dpf_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic signed [WORD_BITS-1:0] psx, psy, pox, poy;
    logic signed [WORD_BITS-1:0] msx, msy, mox, moy;
    logic                        present;
  } pair_t;

  typedef struct {
    logic signed [WORD_BITS-1:0] par;
    logic signed [WORD_BITS-1:0] perp;
    logic                        sat;
  } field_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic pair_valid = 1'b0;
  logic pair_stall;
  logic signed [WORD_BITS-1:0] pos_self_x = '0, pos_self_y = '0;
  logic signed [WORD_BITS-1:0] pos_other_x = '0, pos_other_y = '0;
  logic signed [WORD_BITS-1:0] moment_self_x = '0, moment_self_y = '0;
  logic signed [WORD_BITS-1:0] moment_other_x = '0, moment_other_y = '0;
  logic neighbor_present = 1'b0;
  logic field_valid;
  logic field_stall = 1'b0;
  logic signed [WORD_BITS-1:0] h_parallel, h_perpendicular;
  logic saturated;

  field_t expected_fields[$];
  int errors = 0;
  int cycles = 0;
  int pairs_sent = 0;
  int fields_seen = 0;
  int sat_seen = 0;
  int burst_left = 0;
  bit gaps_on = 1'b1;
  bit hold_req = 1'b0;
  int hold_left = 0;
  int stall_mode = 0;

  dipolar_pair_field i_dut (
    .clk(clk), .rst(rst),
    .pair_valid(pair_valid), .pair_stall(pair_stall),
    .pos_self_x(pos_self_x), .pos_self_y(pos_self_y),
    .pos_other_x(pos_other_x), .pos_other_y(pos_other_y),
    .moment_self_x(moment_self_x), .moment_self_y(moment_self_y),
    .moment_other_x(moment_other_x), .moment_other_y(moment_other_y),
    .neighbor_present(neighbor_present),
    .field_valid(field_valid), .field_stall(field_stall),
    .h_parallel(h_parallel), .h_perpendicular(h_perpendicular),
    .saturated(saturated)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic longint unsigned root_floor(longint unsigned s);
    longint unsigned res, bit_v;
    res = 0;
    bit_v = 64'h4000_0000_0000_0000;
    while (bit_v > s) bit_v >>= 2;
    while (bit_v != 0) begin
      if (s >= res + bit_v) begin
        s -= res + bit_v;
        res = (res >> 1) + bit_v;
      end else begin
        res >>= 1;
      end
      bit_v >>= 2;
    end
    return res;
  endfunction

  function automatic int bit_length(logic [127:0] val);
    int n;
    n = 0;
    for (int i = 0; i < 128; i++) if (val[i]) n = i + 1;
    return n;
  endfunction

  function automatic logic [WORD_BITS-1:0] scale_clamp(logic signed [127:0] t, int x,
                                                       logic [127:0] cube, inout bit sat);
    logic        neg;
    logic [127:0] m, q, limit;
    neg = t[127];
    m = neg ? -t : t;
    limit = neg ? 128'h8000_0000 : 128'h7fff_ffff;
    if (m == 0) return '0;
    if (x >= 0) begin
      if (bit_length(m) + x > 127) begin
        sat = 1'b1;
        q = limit;
      end else begin
        q = (m << x) / cube;
      end
    end else begin
      q = (m / cube) >> (-x);
    end
    if (q > limit) begin
      sat = 1'b1;
      q = limit;
    end
    return neg ? -q[WORD_BITS-1:0] : q[WORD_BITS-1:0];
  endfunction

  function automatic field_t predict_field(pair_t p);
    field_t f;
    longint rx, ry, ux, uy, a, b, c;
    longint unsigned ax, ay, nx, ny, d;
    logic signed [127:0] aw, bw, cw, dot, tpar, tperp;
    logic signed [127:0] mix, miy, mjx, mjy;
    logic [127:0] cube;
    int e, x;
    bit sat;
    f.par = '0;
    f.perp = '0;
    f.sat = 1'b0;
    sat = 1'b0;
    if (!p.present) return f;
    rx = longint'(p.pox) - longint'(p.psx);
    ry = longint'(p.poy) - longint'(p.psy);
    ax = rx < 0 ? -rx : rx;
    ay = ry < 0 ? -ry : ry;
    if (ax == 0 && ay == 0) begin
      f.sat = 1'b1;
      return f;
    end
    e = bit_length(128'(ax > ay ? ax : ay)) - MANT_BITS;
    if (e > 0) begin
      nx = ax >> e;
      ny = ay >> e;
    end else begin
      nx = ax << (-e);
      ny = ay << (-e);
    end
    d = root_floor(nx * nx + ny * ny);
    cube = 128'(d) * 128'(d) * 128'(d);
    ux = (nx << UNIT_BITS) / d;
    uy = (ny << UNIT_BITS) / d;
    if (rx < 0) ux = -ux;
    if (ry < 0) uy = -uy;
    mix = 128'(p.msx);
    miy = 128'(p.msy);
    mjx = 128'(p.mox);
    mjy = 128'(p.moy);
    a = 64'(mjx * ux + mjy * uy);
    b = 64'(mix * ux + miy * uy);
    c = 64'(-miy * ux + mix * uy);
    aw = 128'(a);
    bw = 128'(b);
    cw = 128'(c);
    dot = mjx * mix + mjy * miy;
    tpar = 3 * aw * bw - (dot <<< (2 * UNIT_BITS));
    dot = mjx * (-miy) + mjy * mix;
    tperp = 3 * aw * cw - (dot <<< (2 * UNIT_BITS));
    x = 2 * FRAC_BITS - 2 * UNIT_BITS - 3 * e;
    f.par = scale_clamp(tpar, x, cube, sat);
    f.perp = scale_clamp(tperp, x, cube, sat);
    f.sat = sat;
    return f;
  endfunction

  task automatic report_mismatch(string what, logic [WORD_BITS-1:0] want,
                                 logic [WORD_BITS-1:0] got);
    $display("mismatch %s at cycle %0d: expected %h got %h", what, cycles, want, got);
    errors++;
  endtask

  // Send one request; hold it until accepted, then maybe open a gap.
  task automatic send_pair(pair_t p);
    int gap;
    pos_self_x <= p.psx;
    pos_self_y <= p.psy;
    pos_other_x <= p.pox;
    pos_other_y <= p.poy;
    moment_self_x <= p.msx;
    moment_self_y <= p.msy;
    moment_other_x <= p.mox;
    moment_other_y <= p.moy;
    neighbor_present <= p.present;
    pair_valid <= 1'b1;
    @(posedge clk);
    while (pair_stall) @(posedge clk);
    expected_fields.push_back(predict_field(p));
    pairs_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else if (gaps_on) begin
      burst_left = $urandom_range(0, 12) == 0 ? 40 : $urandom_range(0, 8);
      gap = $urandom_range(0, 5);
      if (gap > 0) begin
        pair_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic go_idle();
    pair_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (expected_fields.size() > 0) @(posedge clk);
  endtask

  function automatic logic signed [WORD_BITS-1:0] rand_word();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
      2: return {1'b0, {(WORD_BITS-1){1'b1}}};
      3: return {1'b1, {(WORD_BITS-1){1'b0}}};
      4: return $urandom() >>> $urandom_range(0, 31);
      default: return $signed($urandom_range(0, 32'h0000_2000)) - 32'sh0000_1000;
    endcase
  endfunction

  function automatic pair_t rand_pair();
    pair_t p;
    int k;
    p.psx = $urandom();
    p.psy = $urandom();
    k = $urandom_range(0, 31);
    case ($urandom_range(0, 4))
      0: begin
        p.pox = $urandom();
        p.poy = $urandom();
      end
      1: begin
        p.pox = p.psx;
        p.poy = p.psy;
      end
      default: begin
        p.pox = p.psx + ($signed($urandom()) >>> k);
        p.poy = p.psy + ($signed($urandom()) >>> ($urandom_range(0, 31)));
      end
    endcase
    if ($urandom_range(0, 30) == 0) begin
      p.pox = p.psx;
      p.poy = p.psy;
    end
    p.msx = rand_word();
    p.msy = rand_word();
    p.mox = rand_word();
    p.moy = rand_word();
    p.present = $urandom_range(0, 9) != 0;
    return p;
  endfunction

  function automatic pair_t make_pair(logic signed [WORD_BITS-1:0] psx, psy, pox, poy,
                                      msx, msy, mox, moy, logic present);
    pair_t p;
    p.psx = psx; p.psy = psy; p.pox = pox; p.poy = poy;
    p.msx = msx; p.msy = msy; p.mox = mox; p.moy = moy;
    p.present = present;
    return p;
  endfunction

  task automatic test_directed();
    logic signed [WORD_BITS-1:0] mx, mn, one, unit;
    mx = {1'b0, {(WORD_BITS-1){1'b1}}};
    mn = {1'b1, {(WORD_BITS-1){1'b0}}};
    one = 1;
    unit = 32'sh0001_0000;
    send_pair(make_pair(0, 0, unit, 0, unit, 0, unit, 0, 1'b1));
    send_pair(make_pair(0, 0, 0, unit, unit, 0, 0, unit, 1'b1));
    send_pair(make_pair(0, 0, unit, unit, unit, unit, -unit, unit, 1'b1));
    send_pair(make_pair(mx, mx, mn, mn, mx, mn, mn, mx, 1'b0));
    send_pair(make_pair(unit, -unit, unit, -unit, unit, unit, unit, unit, 1'b1));
    send_pair(make_pair(mn, mn, mx, mx, mx, mx, mx, mx, 1'b1));
    send_pair(make_pair(mx, mn, mn, mx, mn, mn, mn, mn, 1'b1));
    send_pair(make_pair(mn, 0, mx, 0, mx, 0, mx, 0, 1'b1));
    send_pair(make_pair(0, 0, one, 0, unit, 0, unit, 0, 1'b1));
    send_pair(make_pair(0, 0, 0, -one, mx, mx, mn, mn, 1'b1));
    send_pair(make_pair(0, 0, one, one, 0, 0, 0, 0, 1'b1));
    send_pair(make_pair(0, 0, -unit, 0, mn, mx, mx, mn, 1'b1));
    send_pair(make_pair(-1, -1, 0, 0, one, -one, -one, one, 1'b1));
    send_pair(make_pair(0, 0, 32'sh0010_0000, 32'sh0003_0000, unit, 0, 0, unit, 1'b1));
    send_pair(make_pair(mx, mx, mx, mx, mx, mx, mx, mx, 1'b1));
    send_pair(make_pair(0, 0, mx, mx, -1, -1, -1, -1, 1'b1));
    go_idle();
    wait_drained();
  endtask

  task automatic test_random(int count);
    repeat (count) send_pair(rand_pair());
    go_idle();
  endtask

  task automatic test_backpressure();
    hold_req = 1'b1;
    gaps_on = 1'b0;
    burst_left = 0;
    repeat (250) send_pair(rand_pair());
    gaps_on = 1'b1;
    go_idle();
  endtask

  task automatic test_drain_pause();
    wait_drained();
    repeat (20) @(posedge clk);
    test_random(100);
  endtask

  // Receiver stall: a long hold on request, otherwise a pattern that changes.
  always @(posedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = 400;
    end
    if (cycles % 256 == 0) stall_mode = $urandom_range(0, 3);
    if (hold_left > 0) begin
      hold_left--;
      field_stall <= 1'b1;
    end else begin
      case (stall_mode)
        0: field_stall <= 1'b0;
        1: field_stall <= $urandom_range(0, 9) < 3;
        2: field_stall <= (cycles % 23) < 9;
        default: field_stall <= $urandom_range(0, 9) < 7;
      endcase
    end
  end

  always @(posedge clk) begin
    field_t want;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILURE");
      $finish;
    end
    if (!rst && field_valid && !field_stall) begin
      fields_seen++;
      if (saturated) sat_seen++;
      if (expected_fields.size() == 0) begin
        $display("unexpected field result at cycle %0d", cycles);
        errors++;
      end else begin
        want = expected_fields.pop_front();
        if (h_parallel !== want.par) report_mismatch("h_parallel", want.par, h_parallel);
        if (h_perpendicular !== want.perp)
          report_mismatch("h_perpendicular", want.perp, h_perpendicular);
        if (saturated !== want.sat)
          report_mismatch("saturated", WORD_BITS'(want.sat), WORD_BITS'(saturated));
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(800);
    test_backpressure();
    test_drain_pause();
    test_random(650);
    wait_drained();
    repeat (150) @(posedge clk);
    $display("covered %0d pairs incl. extremes, absent and coincident neighbors", pairs_sent);
    $display("%0d results checked, %0d saturated, long hold and drain pause done",
             fields_seen, sat_seen);
    if (errors == 0 && expected_fields.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
